[rtl/rcast_pkg.sv]
// Shared types, constants and helpers of the column raycaster.
// Used by every module of the block but rcast_ram; depends on nothing.
package rcast_pkg;

   localparam int MAP_DIM_DEF    = 32;
   localparam int SCREEN_MAX_DEF = 2048;

   // Widths of the divider operands, of the side distance accumulators and of the clamped screen size.
   localparam int DIV_NW  = 32;
   localparam int DIV_DW  = 48;
   localparam int DIST_W  = 48;
   localparam int SCR_W   = 13;

   typedef enum logic [1:0] {
      DIV_CAM,
      DIV_DX,
      DIV_DY,
      DIV_LH
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CAM,
      ST_CAM_WAIT,
      ST_RAY,
      ST_DX,
      ST_DX_WAIT,
      ST_DY,
      ST_DY_WAIT,
      ST_SIDE,
      ST_STEP,
      ST_LOOK,
      ST_PERP,
      ST_LH,
      ST_LH_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      REG_POS_X,
      REG_POS_Y,
      REG_DIR_X,
      REG_DIR_Y,
      REG_PLANE_X,
      REG_PLANE_Y,
      REG_WIDTH,
      REG_HEIGHT
   } reg_index_type;

   typedef struct packed {
      logic        clear;
      logic        load;
      logic        cell_we;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_cam;
      logic        ray;
      logic        cap_dx;
      logic        cap_dy;
      logic        side_init;
      logic        step;
      logic        hit;
      logic        perp;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic clr_last;
      logic cam_in_map;
      logic look_hit;
      logic look_exit;
      logic out_free;
   } dp_sts_type;

   function automatic logic [23:0] kind_color(input logic [2:0] kind);
      logic [23:0] c;
      unique case (kind)
         3'd1:    c = 24'hFF0000;
         3'd2:    c = 24'h00FF00;
         3'd3:    c = 24'h0000FF;
         3'd4:    c = 24'hFFFFFF;
         default: c = 24'hFFFF90;
      endcase
      return c;
   endfunction

endpackage

[rtl/rcast_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module rcast_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/rcast_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on rcast_pkg for the operand widths.
module rcast_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rcast_pkg::DIV_NW-1:0] num,
   input  logic [rcast_pkg::DIV_DW-1:0] den,
   output logic [rcast_pkg::DIV_NW-1:0] quo,
   output logic                      done
);
   import rcast_pkg::*;

   localparam int CW = $clog2(DIV_NW + 1);

   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_DW:0]   trial;
   logic              fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_NW-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DW'(trial - {1'b0, den_ff}) : DIV_DW'(trial);
         quo_in = {quo_ff[DIV_NW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;
endmodule

[rtl/rcast_dp.sv]
// Datapath of the raycaster: registers, map RAM, divider, DDA walk and result.
// Depends on rcast_pkg, rcast_ram and rcast_div.
module rcast_dp #(
   parameter int MAP_DIM    = rcast_pkg::MAP_DIM_DEF,
   parameter int SCREEN_MAX = rcast_pkg::SCREEN_MAX_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rcast_pkg::dp_cmd_type   cmd,
   output rcast_pkg::dp_sts_type   sts,
   input  logic                    csr_we,
   input  logic [2:0]              csr_addr,
   input  logic [15:0]             csr_wdata,
   input  logic [23:0]             req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata
);
   import rcast_pkg::*;

   localparam int DEPTH = MAP_DIM * MAP_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAP_DIM);
   localparam int MW    = $clog2(MAP_DIM) + 2;
   localparam int SCW   = $clog2(2 * MAP_DIM + 3);

   // Configuration registers.
   logic [15:0]        posx_ff, posy_ff;
   logic signed [15:0] dirx_ff, diry_ff, plx_ff, ply_ff;
   logic [11:0]        wid_ff, hgt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         posx_ff <= 16'd45056;
         posy_ff <= 16'd24576;
         dirx_ff <= -16'sd16384;
         diry_ff <= '0;
         plx_ff  <= '0;
         ply_ff  <= 16'sd10813;
         wid_ff  <= 12'd640;
         hgt_ff  <= 12'd480;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_POS_X:   posx_ff <= csr_wdata;
            REG_POS_Y:   posy_ff <= csr_wdata;
            REG_DIR_X:   dirx_ff <= csr_wdata;
            REG_DIR_Y:   diry_ff <= csr_wdata;
            REG_PLANE_X: plx_ff  <= csr_wdata;
            REG_PLANE_Y: ply_ff  <= csr_wdata;
            REG_WIDTH:   wid_ff  <= csr_wdata[11:0];
            REG_HEIGHT:  hgt_ff  <= csr_wdata[11:0];
            default:     ;
         endcase
      end
   end

   logic [SCR_W-1:0] w_cl, h_cl;

   always_comb begin
      if (wid_ff == '0)
         w_cl = SCR_W'(1);
      else if (SCR_W'(wid_ff) > SCR_W'(SCREEN_MAX))
         w_cl = SCR_W'(SCREEN_MAX);
      else
         w_cl = SCR_W'(wid_ff);
      if (hgt_ff == '0)
         h_cl = SCR_W'(1);
      else if (SCR_W'(hgt_ff) > SCR_W'(SCREEN_MAX))
         h_cl = SCR_W'(SCREEN_MAX);
      else
         h_cl = SCR_W'(hgt_ff);
   end

   // Map RAM with its clearing sweep and the cell write path.
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] cell_addr, rd_addr;
   logic          cell_ok;
   logic [2:0]    rdata;

   always_ff @(posedge clock) begin
      if (reset)
         clr_ff <= '0;
      else if (cmd.clear)
         clr_ff <= clr_ff + 1'b1;
   end

   assign cell_ok   = (32'(req_tdata[4:0]) < 32'(MAP_DIM)) && (32'(req_tdata[9:5]) < 32'(MAP_DIM));
   assign cell_addr = AW'(32'(req_tdata[4:0]) * 32'(MAP_DIM) + 32'(req_tdata[9:5]));

   rcast_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_map (
      .clock (clock),
      .we    (cmd.clear || (cmd.cell_we && cell_ok)),
      .waddr (cmd.clear ? clr_ff : cell_addr),
      .wdata (cmd.clear ? 3'd0 : req_tdata[12:10]),
      .raddr (rd_addr),
      .rdata (rdata)
   );

   // Per-cast registers.
   logic [10:0]         col_ff;
   logic signed [27:0]  cam_ff;
   logic signed [31:0]  rx_ff, ry_ff;
   logic [31:0]         dx_ff, dy_ff;
   logic [DIST_W-1:0]   sx_ff, sy_ff, perp_ff;
   logic signed [MW-1:0] mx_ff, my_ff, mx_in, my_in;
   logic [SCW-1:0]      steps_ff;
   logic                side_ff, found_ff;
   logic [2:0]          kind_ff;
   logic [31:0]         rxa, rya;

   assign rxa = rx_ff[31] ? 32'(-rx_ff) : 32'(rx_ff);
   assign rya = ry_ff[31] ? 32'(-ry_ff) : 32'(ry_ff);

   // Divider operand selection.
   logic [DIV_NW-1:0] div_num, quo;
   logic [DIV_DW-1:0] div_den;
   logic              div_done;

   always_comb begin
      unique case (cmd.div_sel)
         DIV_CAM: begin
            div_num = DIV_NW'({col_ff, 15'd0});
            div_den = DIV_DW'(w_cl);
         end
         DIV_DX: begin
            div_num = DIV_NW'(32'h4000_0000);
            div_den = DIV_DW'(rxa);
         end
         DIV_DY: begin
            div_num = DIV_NW'(32'h4000_0000);
            div_den = DIV_DW'(rya);
         end
         default: begin
            div_num = DIV_NW'({h_cl, 16'd0});
            div_den = perp_ff;
         end
      endcase
   end

   rcast_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (quo),
      .done  (div_done)
   );

   // Ray direction products.
   logic signed [43:0] prodx, prody;
   assign prodx = plx_ff * cam_ff;
   assign prody = ply_ff * cam_ff;

   // Initial side distances.
   logic [11:0] fx, fy;
   logic [43:0] sxp, syp;
   assign fx  = rx_ff[31] ? {1'b0, posx_ff[10:0]} : 12'd2048 - {1'b0, posx_ff[10:0]};
   assign fy  = ry_ff[31] ? {1'b0, posy_ff[10:0]} : 12'd2048 - {1'b0, posy_ff[10:0]};
   assign sxp = 44'(fx) * 44'(dx_ff);
   assign syp = 44'(fy) * 44'(dy_ff);

   // One DDA step.
   logic take_x;
   assign take_x = sx_ff < sy_ff;

   always_comb begin
      mx_in = mx_ff;
      my_in = my_ff;
      if (take_x)
         mx_in = rx_ff[31] ? mx_ff - 1'b1 : mx_ff + 1'b1;
      else
         my_in = ry_ff[31] ? my_ff - 1'b1 : my_ff + 1'b1;
   end

   assign rd_addr = AW'(32'(mx_in[IW-1:0]) * 32'(MAP_DIM) + 32'(my_in[IW-1:0]));

   logic oob;
   assign oob = mx_ff[MW-1] || my_ff[MW-1] ||
                (mx_ff >= $signed(MW'(MAP_DIM))) || (my_ff >= $signed(MW'(MAP_DIM)));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff   <= req_tdata[23:13];
         found_ff <= 1'b0;
      end
      if (cmd.cap_cam)
         cam_ff <= signed'(28'(quo)) - 28'sd16384;
      if (cmd.ray) begin
         rx_ff <= 32'(dirx_ff) + 32'(prodx >>> 14);
         ry_ff <= 32'(diry_ff) + 32'(prody >>> 14);
      end
      if (cmd.cap_dx)
         dx_ff <= (rxa == '0) ? 32'hFFFF_FFFF : quo;
      if (cmd.cap_dy)
         dy_ff <= (rya == '0) ? 32'hFFFF_FFFF : quo;
      if (cmd.side_init) begin
         sx_ff    <= DIST_W'(sxp >> 11);
         sy_ff    <= DIST_W'(syp >> 11);
         mx_ff    <= MW'(posx_ff[15:11]);
         my_ff    <= MW'(posy_ff[15:11]);
         steps_ff <= '0;
         side_ff  <= 1'b0;
      end
      if (cmd.step) begin
         if (take_x) begin
            sx_ff   <= sx_ff + DIST_W'(dx_ff);
            side_ff <= 1'b0;
         end else begin
            sy_ff   <= sy_ff + DIST_W'(dy_ff);
            side_ff <= 1'b1;
         end
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.hit) begin
         found_ff <= 1'b1;
         kind_ff  <= rdata;
      end
      if (cmd.perp)
         perp_ff <= side_ff ? sy_ff - DIST_W'(dy_ff) : sx_ff - DIST_W'(dx_ff);
   end

   // Stripe rows and color.
   logic [31:0] lh, hh, lh2, ds;
   logic [32:0] de_sum, de;
   logic [23:0] color;

   always_comb begin
      lh     = (perp_ff == '0) ? 32'(4 * SCREEN_MAX) : quo;
      hh     = 32'(h_cl >> 1);
      lh2    = lh >> 1;
      ds     = (hh > lh2) ? hh - lh2 : '0;
      de_sum = 33'(lh2) + 33'(hh);
      de     = (de_sum >= 33'(h_cl)) ? 33'(h_cl) - 33'd1 : de_sum;
      color  = kind_color(kind_ff);
      if (side_ff)
         color = color >> 1;
   end

   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff, rsp_data_in;

   assign rsp_data_in = found_ff ?
      {2'b00, kind_ff, 1'b1, side_ff, color, de[10:0], ds[10:0], col_ff} :
      {53'd0, col_ff};

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.out_load)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
      if (cmd.out_load)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sts.div_done   = div_done;
   assign sts.clr_last   = clr_ff == AW'(DEPTH - 1);
   assign sts.cam_in_map = (32'(posx_ff[15:11]) < 32'(MAP_DIM)) &&
                           (32'(posy_ff[15:11]) < 32'(MAP_DIM));
   assign sts.look_hit   = !oob && (rdata != 3'd0);
   assign sts.look_exit  = oob || (steps_ff == SCW'(2 * MAP_DIM + 2));
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;
endmodule

[rtl/rcast_ctrl.sv]
// Controller of the raycaster: sequences clearing, cell writes and casts.
// Depends on rcast_pkg.
module rcast_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tuser,
   output logic                  req_tready,
   input  rcast_pkg::dp_sts_type sts,
   output rcast_pkg::dp_cmd_type cmd
);
   import rcast_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:     if (accept && req_tuser) state_in = ST_CAM;
         ST_CAM:      state_in = ST_CAM_WAIT;
         ST_CAM_WAIT: if (sts.div_done) state_in = ST_RAY;
         ST_RAY:      state_in = ST_DX;
         ST_DX:       state_in = ST_DX_WAIT;
         ST_DX_WAIT:  if (sts.div_done) state_in = ST_DY;
         ST_DY:       state_in = ST_DY_WAIT;
         ST_DY_WAIT:  if (sts.div_done) state_in = ST_SIDE;
         ST_SIDE:     state_in = sts.cam_in_map ? ST_STEP : ST_FINISH;
         ST_STEP:     state_in = ST_LOOK;
         ST_LOOK: begin
            priority if (sts.look_hit) state_in = ST_PERP;
            else if (sts.look_exit)    state_in = ST_FINISH;
            else                       state_in = ST_STEP;
         end
         ST_PERP:     state_in = ST_LH;
         ST_LH:       state_in = ST_LH_WAIT;
         ST_LH_WAIT:  if (sts.div_done) state_in = ST_FINISH;
         ST_FINISH:   if (sts.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.div_sel = DIV_CAM;
      req_tready  = state_ff == ST_IDLE;
      unique case (state_ff)
         ST_CLEAR:    cmd.clear = 1'b1;
         ST_IDLE: begin
            cmd.load    = accept && req_tuser;
            cmd.cell_we = accept && !req_tuser;
         end
         ST_CAM:      cmd.div_start = 1'b1;
         ST_CAM_WAIT: cmd.cap_cam = sts.div_done;
         ST_RAY:      cmd.ray = 1'b1;
         ST_DX: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_DX;
         end
         ST_DX_WAIT: begin
            cmd.div_sel = DIV_DX;
            cmd.cap_dx  = sts.div_done;
         end
         ST_DY: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_DY;
         end
         ST_DY_WAIT: begin
            cmd.div_sel = DIV_DY;
            cmd.cap_dy  = sts.div_done;
         end
         ST_SIDE:     cmd.side_init = 1'b1;
         ST_STEP:     cmd.step = 1'b1;
         ST_LOOK:     cmd.hit = sts.look_hit;
         ST_PERP:     cmd.perp = 1'b1;
         ST_LH: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_LH;
         end
         ST_LH_WAIT:  cmd.div_sel = DIV_LH;
         ST_FINISH:   cmd.out_load = sts.out_free;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_CLEAR;
      else
         state_ff <= state_in;
   end
endmodule

[rtl/grid_dda_column_raycaster_unit.sv]
// Column raycaster: one map cell write or one DDA cast per request beat, one beat at a time.
// A cast runs three divisions (four on a hit) in the shared divider, and a step and a
// lookup with one RAM read for each map cell walked.
// After reset the map RAM is swept to zero, one cell a cycle (MAP_DIM * MAP_DIM cells,
// 1024 by default); no request beat is taken during the sweep, configuration writes are.
// Reset is synchronous and active high; it restores the default camera and screen size.
module grid_dda_column_raycaster_unit #(
   parameter int MAP_DIM    = rcast_pkg::MAP_DIM_DEF,
   parameter int SCREEN_MAX = rcast_pkg::SCREEN_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cell_row, cell_col, cell_kind, column
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_column, draw_start, draw_end, wall_color,
                                    // hit_side, wall_found, hit_kind, zero fill
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import rcast_pkg::*;

   // The controller steps through the cast; the datapath holds all arithmetic, the map
   // and the result register. The result register frees the controller to take the next
   // request beat while a finished result still waits on the response side.
   dp_cmd_type cmd;
   dp_sts_type sts;

   rcast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rcast_dp #(.MAP_DIM(MAP_DIM), .SCREEN_MAX(SCREEN_MAX)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

[bench/tb_grid_dda_column_raycaster_unit.sv]
// Self-checking bench for the grid DDA column raycaster unit.
// Needs rcast_pkg and grid_dda_column_raycaster_unit; drives both streams and the CSR port.
`timescale 1ns / 1ps

module tb_grid_dda_column_raycaster_unit;
   import rcast_pkg::*;

   localparam int MAP_N      = MAP_DIM_DEF;
   localparam int SCR_LIMIT  = SCREEN_MAX_DEF;
   localparam int DRAIN_CYC  = 300;    // longest cast plus margin
   localparam int WDOG_LIMIT = 40000;  // idle cycles without any beat
   localparam int N_PHASES   = 6;
   localparam int N_RANDOM   = 100;    // random beats per phase

   // Result beat, laid out exactly as rsp_tdata (lowest field last here).
   typedef struct packed {
      logic [1:0]  pad;
      logic [2:0]  kind;
      logic        found;
      logic        side;
      logic [23:0] color;
      logic [10:0] row_end;
      logic [10:0] row_start;
      logic [10:0] column;
   } stripe_type;

   typedef struct {
      logic        cast;
      logic [4:0]  row;
      logic [4:0]  col;
      logic [2:0]  kind;
      logic [10:0] column;
      logic        typed;      // expected result is given in the row
      stripe_type  stripe;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [15:0] csr_wdata;

   grid_dda_column_raycaster_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the tile map and of the camera registers.
   logic [2:0]  tile_map [MAP_N*MAP_N];
   logic [15:0] cam_regs [8];

   stripe_type stripe_q [$];
   int         mismatches = 0;
   int         idle_count = 0;
   int         send_idle_pct;
   int         recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Predicts the stripe of one screen column from the shadow map and registers.
   function automatic stripe_type cast_column(input logic [10:0] column);
      stripe_type       s;
      longint           w, h, cam, rx, ry, lh, ds, de;
      longint unsigned  dx, dy, sx, sy, perp, mag;
      int               mx, my, stx, sty, side, found, n;
      logic [2:0]       kind;
      logic [10:0]      fx, fy;
      logic [23:0]      color;
      w = cam_regs[REG_WIDTH][11:0];
      h = cam_regs[REG_HEIGHT][11:0];
      if (w < 1) w = 1;
      if (w > SCR_LIMIT) w = SCR_LIMIT;
      if (h < 1) h = 1;
      if (h > SCR_LIMIT) h = SCR_LIMIT;
      cam = (longint'(column) * 32768) / w - 16384;
      // Arithmetic shift of a signed product is a floor division by 2^14.
      rx = longint'($signed(cam_regs[REG_DIR_X]))
         + ((longint'($signed(cam_regs[REG_PLANE_X])) * cam) >>> 14);
      ry = longint'($signed(cam_regs[REG_DIR_Y]))
         + ((longint'($signed(cam_regs[REG_PLANE_Y])) * cam) >>> 14);
      mx = cam_regs[REG_POS_X][15:11];
      my = cam_regs[REG_POS_Y][15:11];
      fx = cam_regs[REG_POS_X][10:0];
      fy = cam_regs[REG_POS_Y][10:0];
      // A zero ray component gives a saturated step length.
      mag = (rx < 0) ? -rx : rx;
      dx = (mag == 0) ? 64'hFFFF_FFFF : (64'd1 << 30) / mag;
      mag = (ry < 0) ? -ry : ry;
      dy = (mag == 0) ? 64'hFFFF_FFFF : (64'd1 << 30) / mag;
      if (rx < 0) begin
         stx = -1;
         sx = (longint'(fx) * dx) >> 11;
      end else begin
         stx = 1;
         sx = ((2048 - longint'(fx)) * dx) >> 11;
      end
      if (ry < 0) begin
         sty = -1;
         sy = (longint'(fy) * dy) >> 11;
      end else begin
         sty = 1;
         sy = ((2048 - longint'(fy)) * dy) >> 11;
      end
      side = 0;
      found = 0;
      kind = 3'd0;
      if (mx < MAP_N && my < MAP_N) begin
         for (n = 0; n < 2 * MAP_N + 2; n++) begin
            // On a tie of side distances the y step is taken.
            if (sx < sy) begin
               sx += dx;
               mx += stx;
               side = 0;
            end else begin
               sy += dy;
               my += sty;
               side = 1;
            end
            if (mx < 0 || my < 0 || mx >= MAP_N || my >= MAP_N) break;
            kind = tile_map[mx * MAP_N + my];
            if (kind != 3'd0) begin
               found = 1;
               break;
            end
         end
      end
      s = '0;
      s.column = column;
      if (found == 0) return s;
      perp = side ? sy - dy : sx - dx;
      if (perp == 0) lh = 4 * SCR_LIMIT;
      else lh = longint'((unsigned'(h) << 16) / perp);
      ds = h / 2 - lh / 2;
      if (ds < 0) ds = 0;
      de = lh / 2 + h / 2;
      if (de >= h) de = h - 1;
      case (kind)
         3'd1:    color = 24'hFF0000;
         3'd2:    color = 24'h00FF00;
         3'd3:    color = 24'h0000FF;
         3'd4:    color = 24'hFFFFFF;
         default: color = 24'hFFFF90;
      endcase
      if (side != 0) color = color >> 1;
      s.row_start = ds[10:0];
      s.row_end = de[10:0];
      s.color = color;
      s.side = side[0];
      s.found = 1'b1;
      s.kind = kind;
      return s;
   endfunction

   // Result side: random stalls, and each beat is checked against the oldest prediction.
   always @(posedge clock) begin
      stripe_type got, want;
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (stripe_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: %h", rsp_tdata);
         end else begin
            want = stripe_q.pop_front();
            if (got.column !== want.column || got.row_start !== want.row_start
                || got.row_end !== want.row_end || got.color !== want.color
                || got.side !== want.side || got.found !== want.found
                || got.kind !== want.kind || got.pad !== 2'b00) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch col %0d: exp start %0d end %0d color %h side %b",
                            " found %b kind %0d, got col %0d start %0d end %0d color %h",
                            " side %b found %b kind %0d pad %b"},
                     want.column, want.row_start, want.row_end, want.color, want.side,
                     want.found, want.kind, got.column, got.row_start, got.row_end,
                     got.color, got.side, got.found, got.kind, got.pad);
            end
         end
      end
   end

   // Watchdog: any beat on either stream restarts the count.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Sends one request beat after a random gap and updates the prediction once it is taken.
   task automatic send_beat(input logic cast, input logic [4:0] row, input logic [4:0] col,
                            input logic [2:0] kind, input logic [10:0] column,
                            input logic typed, input stripe_type stripe);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cast;
      req_tdata <= {column, kind, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cast) begin
         if (typed) stripe_q.push_back(stripe);
         else stripe_q.push_back(cast_column(column));
      end else begin
         tile_map[row * MAP_N + col] = kind;
      end
   endtask

   // Waits until every cast has answered, then lets a possible last cell write settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (stripe_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // Writes all eight camera registers back to back; no cast is in flight here.
   task automatic load_camera(input logic [15:0] vals [8]);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_addr <= i[2:0];
         csr_wdata <= vals[i];
         cam_regs[i] = (i >= REG_WIDTH) ? {4'h0, vals[i][11:0]} : vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic stripe_type miss(input logic [10:0] column);
      stripe_type s;
      s = '0;
      s.column = column;
      return s;
   endfunction

   initial begin
      dir_row_type rows [$];
      dir_row_type r;
      logic [15:0] vals [8];
      stripe_type  hit0;
      int          w;
      logic        cast;
      logic [10:0] column;
      logic [2:0]  kind;

      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      foreach (tile_map[i]) tile_map[i] = 3'd0;
      cam_regs = '{16'd45056, 16'd24576, 16'hC000, 16'd0, 16'd0, 16'd10813, 16'd640, 16'd480};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wall right in front of the camera, which sits on a cell boundary: the center
      // column has a zero y component and a zero perpendicular distance, so the
      // stripe covers the whole screen height.
      hit0 = '0;
      hit0.column = 11'd320;
      hit0.row_start = 11'd0;
      hit0.row_end = 11'd479;
      hit0.color = 24'hFF0000;
      hit0.found = 1'b1;
      hit0.kind = 3'd1;

      // Directed rows: empty map misses first, then walls of every kind, a cleared cell and casts.
      rows.push_back('{1'b1, 5'd0,  5'd0,  3'd0, 11'd0,    1'b1, miss(11'd0)});
      rows.push_back('{1'b1, 5'd0,  5'd0,  3'd0, 11'd320,  1'b1, miss(11'd320)});
      rows.push_back('{1'b1, 5'd31, 5'd31, 3'd7, 11'd2047, 1'b1, miss(11'd2047)});
      rows.push_back('{1'b0, 5'd21, 5'd12, 3'd1, 11'd0,    1'b0, '0});
      rows.push_back('{1'b1, 5'd0,  5'd0,  3'd0, 11'd320,  1'b1, hit0});
      rows.push_back('{1'b0, 5'd20, 5'd11, 3'd2, 11'd2047, 1'b0, '0});
      rows.push_back('{1'b0, 5'd20, 5'd13, 3'd3, 11'd0,    1'b0, '0});
      rows.push_back('{1'b0, 5'd19, 5'd10, 3'd4, 11'd0,    1'b0, '0});
      rows.push_back('{1'b0, 5'd19, 5'd14, 3'd5, 11'd0,    1'b0, '0});
      rows.push_back('{1'b0, 5'd0,  5'd0,  3'd6, 11'd0,    1'b0, '0});
      rows.push_back('{1'b0, 5'd31, 5'd31, 3'd7, 11'd0,    1'b0, '0});
      rows.push_back('{1'b0, 5'd21, 5'd12, 3'd0, 11'd0,    1'b0, '0});
      rows.push_back('{1'b1, 5'd0,  5'd0,  3'd0, 11'd0,    1'b0, '0});
      rows.push_back('{1'b1, 5'd0,  5'd0,  3'd0, 11'd100,  1'b0, '0});
      rows.push_back('{1'b1, 5'd0,  5'd0,  3'd0, 11'd250,  1'b0, '0});
      rows.push_back('{1'b1, 5'd0,  5'd0,  3'd0, 11'd400,  1'b0, '0});
      rows.push_back('{1'b1, 5'd0,  5'd0,  3'd0, 11'd639,  1'b0, '0});
      rows.push_back('{1'b1, 5'd0,  5'd0,  3'd0, 11'd1500, 1'b0, '0});

      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         // Camera settings: defaults, three sets of edge values, then random ones.
         case (p)
            0: vals = '{16'd45056, 16'd24576, 16'hC000, 16'd0, 16'd0, 16'd10813,
                        16'd640, 16'd480};
            1: vals = '{16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd0, 16'd1, 16'd1};
            2: vals = '{16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                        16'd2048, 16'd2048};
            3: vals = '{16'd33792, 16'd33792, 16'd0, 16'd16384, 16'd10813, 16'd0,
                        16'd0, 16'hFFFF};
            default: begin
               vals[0] = 16'($urandom_range(65535));
               vals[1] = 16'($urandom_range(65535));
               for (int i = 2; i < 6; i++) vals[i] = 16'($urandom_range(65535));
               vals[6] = 16'($urandom_range(2048, 1));
               vals[7] = 16'($urandom_range(2048, 1));
            end
         endcase
         load_camera(vals);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         if (p == 0)
            foreach (rows[i])
               send_beat(rows[i].cast, rows[i].row, rows[i].col, rows[i].kind,
                         rows[i].column, rows[i].typed, rows[i].stripe);
         w = cam_regs[REG_WIDTH][11:0];
         if (w < 1) w = 1;
         if (w > SCR_LIMIT) w = SCR_LIMIT;
         for (int n = 0; n < N_RANDOM; n++) begin
            // Sender holds off once until every cast has answered.
            if (p == 1 && n == N_RANDOM / 2)
               while (stripe_q.size() != 0) begin
                  req_tvalid <= 1'b0;
                  @(posedge clock);
               end
            cast = ($urandom_range(99) < 70);
            // Columns mostly fall on the screen, the rest anywhere in the field.
            if ($urandom_range(99) < 80) column = 11'($urandom_range(w - 1));
            else column = 11'($urandom_range(2047));
            // Open tiles are common so rays travel some distance before a hit.
            kind = ($urandom_range(99) < 40) ? 3'd0 : 3'($urandom_range(7, 1));
            if (!cast && $urandom_range(99) < 20) column = 11'($urandom_range(2047));
            send_beat(cast, 5'($urandom_range(31)), 5'($urandom_range(31)), kind, column,
                      1'b0, '0);
         end
      end

      drain();
      if (mismatches == 0 && stripe_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
